FILE: rtl/core/sgmd_pkg.sv
package sgmd_pkg;

  // default frame limits
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // register reset values
  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;

  // register indexes
  localparam logic [0:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_FRAME_HEIGHT = 1'b1;

  // input kinds
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // angle arithmetic, units of 2^-20 rad
  localparam int CORDIC_STEPS = 20;
  localparam int ANGLE_HALF_PI = 1647099;
  localparam int ANGLE_PI      = 3294199;

  localparam logic [20:0] ATAN_TAB [CORDIC_STEPS] = '{
    21'd823550, 21'd486170, 21'd256879, 21'd130396, 21'd65451,
    21'd32757,  21'd16383,  21'd8192,   21'd4096,   21'd2048,
    21'd1024,   21'd512,    21'd256,    21'd128,    21'd64,
    21'd32,     21'd16,     21'd8,      21'd4,      21'd2
  };

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_PIX,
    S_DRA,
    S_DRB,
    S_DRC,
    S_GRAD,
    S_SQ,
    S_CALC,
    S_FIN
  } sgmd_state_t;

  // saturate a dimension register to 1..maxv
  function automatic int clamp_dim(input logic [10:0] v, input int maxv);
    if (v == 11'd0) return 1;
    if (int'(v) > maxv) return maxv;
    return int'(v);
  endfunction

endpackage

FILE: rtl/core/sgmd_ram.sv
module sgmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/sobel_gradient_mag_dir.sv
// 3x3 Sobel edge detector on 8-bit grey pixels in raster order, borders
// replicated. Each result carries grad_x, grad_y, floor(sqrt(gx^2+gy^2)) and
// atan2(gy, gx) in signed Q3.13 radians, plus its row and column; tlast marks
// the last result of a frame. Results trail the input by width+1 pixels; once
// the whole frame is in, each drain transfer (tuser = 1) releases one pending
// result, and the frame counters restart after the last one. The two previous
// rows live in two line memories that are read and written back per pixel.
// A pixel that gives a result then goes through the gradient, square,
// CORDIC and output states; the CORDIC angle unit runs 20 steps, one step
// per cycle, with the square root beside it. A drain on the last row first
// reads it back from line memory. Line memories need no clearing after reset.
module sobel_gradient_mag_dir #(
  parameter int MAX_WIDTH  = sgmd_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgmd_pkg::MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // pixel[7:0]
  input  logic [0:0]  in_tuser,   // command[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // grad_x[10:0], grad_y[21:11], magnitude[32:22],
                                  // direction[48:33], out_row[58:49], out_col[68:59]
  output logic        out_tlast,  // frame_end
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [10:0] cfg_wdata
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int LAST_STEP = sgmd_pkg::CORDIC_STEPS - 1;

  sgmd_pkg::sgmd_state_t state_r, state_nxt;

  logic [WW-1:0] w_r;
  logic [HW-1:0] h_r;
  logic [AW-1:0] in_col_r;
  logic [RW-1:0] in_row_r;
  logic          in_done_r;
  logic [AW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic [7:0]    win_r [3][3];
  logic [4:0]    step_r;
  logic          out_valid_r;

  logic [7:0]    pix_r;
  logic [7:0]    dup_r [2];
  logic [7:0]    dmid_r [2];
  logic [7:0]    ewin_r [3][3];
  logic [RW-1:0] e_row_r;
  logic [AW-1:0] e_col_r;
  logic          e_last_r;
  logic signed [10:0] gx_r, gy_r;
  logic signed [32:0] cx_r, cy_r;
  logic signed [22:0] cz_r;
  logic          num_zero_r, swapped_r, gx_neg_r, gy_neg_r;
  logic [21:0]   sq_op_r, sq_res_r, sq_one_r;
  logic [71:0]   out_data_r;
  logic          out_last_r;

  logic          in_xfer, out_free;
  logic          is_pixel;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [7:0]    up_rd, mid_rd;
  logic          emit_go, emit_last;
  logic [7:0]    ewin_nxt [3][3];
  logic [7:0]    pcol [3];
  logic          h_ge2, row_ge1, row_ge2, row_eq1, x_zero, drain_win;
  logic [AW-1:0] c0, c2;

  assign in_tready = (state_r == sgmd_pkg::S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign is_pixel  = (in_tuser[0] == sgmd_pkg::CMD_PIXEL);
  assign out_free  = !out_valid_r || out_tready;

  // line memories
  sgmd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_upper (
    .clk(clk), .we(mem_we), .waddr(in_col_r), .wdata(mid_rd),
    .raddr(rd_addr), .rdata(up_rd)
  );

  sgmd_ram #(.WIDTH(8), .DEPTH(MAX_WIDTH)) u_middle (
    .clk(clk), .we(mem_we), .waddr(in_col_r), .wdata(pix_r),
    .raddr(rd_addr), .rdata(mid_rd)
  );

  // position flags
  assign h_ge2     = 32'(h_r) >= 32'd2;
  assign row_ge1   = in_row_r != '0;
  assign row_ge2   = 32'(in_row_r) >= 32'd2;
  assign row_eq1   = 32'(in_row_r) == 32'd1;
  assign x_zero    = in_col_r == '0;
  assign drain_win = (32'(out_row_r) + 32'd1) < 32'(h_r);
  assign emit_last = ((32'(out_col_r) + 32'd1) == 32'(w_r)) &&
                     ((32'(out_row_r) + 32'd1) == 32'(h_r));
  assign c0 = (out_col_r == '0) ? '0 : out_col_r - AW'(1);
  assign c2 = ((32'(out_col_r) + 32'd1) < 32'(w_r)) ? out_col_r + AW'(1) : out_col_r;

  // new window column from the line memories
  assign pcol[0] = row_ge2 ? up_rd : (row_eq1 ? mid_rd : pix_r);
  assign pcol[1] = row_ge1 ? mid_rd : pix_r;
  assign pcol[2] = pix_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sgmd_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (is_pixel) begin
            if (!in_done_r) state_nxt = sgmd_pkg::S_PIX;
          end else if (in_done_r) begin
            state_nxt = drain_win ? sgmd_pkg::S_GRAD : sgmd_pkg::S_DRA;
          end
        end
      end
      sgmd_pkg::S_PIX:  state_nxt = emit_go ? sgmd_pkg::S_GRAD : sgmd_pkg::S_IDLE;
      sgmd_pkg::S_DRA:  state_nxt = sgmd_pkg::S_DRB;
      sgmd_pkg::S_DRB:  state_nxt = sgmd_pkg::S_DRC;
      sgmd_pkg::S_DRC:  state_nxt = sgmd_pkg::S_GRAD;
      sgmd_pkg::S_GRAD: state_nxt = sgmd_pkg::S_SQ;
      sgmd_pkg::S_SQ:   state_nxt = sgmd_pkg::S_CALC;
      sgmd_pkg::S_CALC: begin
        if (32'(step_r) == LAST_STEP) state_nxt = sgmd_pkg::S_FIN;
      end
      sgmd_pkg::S_FIN: begin
        if (out_free) state_nxt = sgmd_pkg::S_IDLE;
      end
      default: state_nxt = sgmd_pkg::S_IDLE;
    endcase
  end

  // memory access and emit selection
  always_comb begin
    rd_addr  = in_col_r;
    mem_we   = 1'b0;
    emit_go  = 1'b0;
    ewin_nxt = ewin_r;
    unique case (state_r)
      sgmd_pkg::S_IDLE: begin
        if (in_xfer && !is_pixel && in_done_r) begin
          if (drain_win) begin
            emit_go     = 1'b1;
            ewin_nxt[0] = win_r[1];
            ewin_nxt[1] = win_r[2];
            ewin_nxt[2] = win_r[2];
          end else begin
            rd_addr = c0;
          end
        end
      end
      sgmd_pkg::S_PIX: begin
        mem_we = 1'b1;
        if (x_zero) begin
          if (row_ge2) begin
            emit_go     = 1'b1;
            ewin_nxt[0] = win_r[1];
            ewin_nxt[1] = win_r[2];
            ewin_nxt[2] = win_r[2];
          end
        end else if (row_ge1) begin
          emit_go     = 1'b1;
          ewin_nxt[0] = win_r[1];
          ewin_nxt[1] = win_r[2];
          ewin_nxt[2] = pcol;
        end
      end
      sgmd_pkg::S_DRA: rd_addr = out_col_r;
      sgmd_pkg::S_DRB: rd_addr = c2;
      sgmd_pkg::S_DRC: begin
        emit_go     = 1'b1;
        ewin_nxt[0] = '{h_ge2 ? dup_r[0] : dmid_r[0], dmid_r[0], dmid_r[0]};
        ewin_nxt[1] = '{h_ge2 ? dup_r[1] : dmid_r[1], dmid_r[1], dmid_r[1]};
        ewin_nxt[2] = '{h_ge2 ? up_rd : mid_rd, mid_rd, mid_rd};
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sgmd_pkg::S_IDLE;
      w_r         <= WW'(sgmd_pkg::clamp_dim(11'(sgmd_pkg::RESET_WIDTH), MAX_WIDTH));
      h_r         <= HW'(sgmd_pkg::clamp_dim(11'(sgmd_pkg::RESET_HEIGHT), MAX_HEIGHT));
      in_col_r    <= '0;
      in_row_r    <= '0;
      in_done_r   <= 1'b0;
      out_col_r   <= '0;
      out_row_r   <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
      for (int c = 0; c < 3; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[c][r] <= '0;
        end
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          sgmd_pkg::CFG_FRAME_WIDTH:
            w_r <= WW'(sgmd_pkg::clamp_dim(cfg_wdata, MAX_WIDTH));
          sgmd_pkg::CFG_FRAME_HEIGHT:
            h_r <= HW'(sgmd_pkg::clamp_dim(cfg_wdata, MAX_HEIGHT));
          default: begin
          end
        endcase
        in_col_r  <= '0;
        in_row_r  <= '0;
        in_done_r <= 1'b0;
        out_col_r <= '0;
        out_row_r <= '0;
      end else begin
        // pixel position and window shift
        if (state_r == sgmd_pkg::S_PIX) begin
          if ((32'(in_col_r) + 32'd1) == 32'(w_r)) begin
            in_col_r <= '0;
            if ((32'(in_row_r) + 32'd1) == 32'(h_r)) begin
              in_done_r <= 1'b1;
            end else begin
              in_row_r <= in_row_r + RW'(1);
            end
          end else begin
            in_col_r <= in_col_r + AW'(1);
          end
          if (x_zero) begin
            win_r[0] <= pcol;
            win_r[1] <= pcol;
            win_r[2] <= pcol;
          end else begin
            win_r[0] <= win_r[1];
            win_r[1] <= win_r[2];
            win_r[2] <= pcol;
          end
        end
        // result position, frame restart after the last one
        if (emit_go) begin
          if (emit_last) begin
            out_col_r <= '0;
            out_row_r <= '0;
            in_col_r  <= '0;
            in_row_r  <= '0;
            in_done_r <= 1'b0;
          end else if ((32'(out_col_r) + 32'd1) == 32'(w_r)) begin
            out_col_r <= '0;
            out_row_r <= out_row_r + RW'(1);
          end else begin
            out_col_r <= out_col_r + AW'(1);
          end
        end
      end
      if (state_r == sgmd_pkg::S_SQ) begin
        step_r <= '0;
      end else if (state_r == sgmd_pkg::S_CALC) begin
        step_r <= step_r + 5'd1;
      end
      if (state_r == sgmd_pkg::S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // truncate toward zero on right shift
  function automatic logic signed [32:0] shr_tz(input logic signed [32:0] v,
                                                 input logic [4:0] s);
    logic signed [32:0] mv;
    mv = -v;
    if (v[32]) return -(mv >>> s);
    return v >>> s;
  endfunction

  logic [11:0] sum_r, sum_l, sum_b, sum_t;
  logic [10:0] ax, ay, num, den;
  logic signed [21:0] sqx, sqy;
  logic signed [32:0] xs, ys;
  logic [21:0] sq_t;
  logic signed [23:0] z0, z1, z2, z3;
  logic [23:0] zmag, zround;
  logic [15:0] dir;
  logic [RW+9:0] row_ext;
  logic [AW+9:0] col_ext;

  // gradient sums
  assign sum_r = 12'(ewin_r[2][0]) + {3'b0, ewin_r[2][1], 1'b0} + 12'(ewin_r[2][2]);
  assign sum_l = 12'(ewin_r[0][0]) + {3'b0, ewin_r[0][1], 1'b0} + 12'(ewin_r[0][2]);
  assign sum_b = 12'(ewin_r[0][2]) + {3'b0, ewin_r[1][2], 1'b0} + 12'(ewin_r[2][2]);
  assign sum_t = 12'(ewin_r[0][0]) + {3'b0, ewin_r[1][0], 1'b0} + 12'(ewin_r[2][0]);

  // octant fold and squares
  assign ax  = gx_r[10] ? 11'(-gx_r) : 11'(gx_r);
  assign ay  = gy_r[10] ? 11'(-gy_r) : 11'(gy_r);
  assign num = (ay > ax) ? ax : ay;
  assign den = (ay > ax) ? ay : ax;
  assign sqx = 22'(gx_r) * 22'(gx_r);
  assign sqy = 22'(gy_r) * 22'(gy_r);

  // one cordic step and one square root digit
  assign xs   = shr_tz(cx_r, step_r);
  assign ys   = shr_tz(cy_r, step_r);
  assign sq_t = sq_res_r + sq_one_r;

  // angle unfold and rounding to q3.13
  assign z0 = num_zero_r ? 24'sd0 : 24'(cz_r);
  assign z1 = swapped_r ? 24'(sgmd_pkg::ANGLE_HALF_PI) - z0 : z0;
  assign z2 = gx_neg_r ? 24'(sgmd_pkg::ANGLE_PI) - z1 : z1;
  assign z3 = gy_neg_r ? -z2 : z2;
  assign zmag   = z3[23] ? 24'(-z3) : 24'(z3);
  assign zround = (zmag + 24'd64) >> 7;
  assign dir    = z3[23] ? 16'(-zround) : 16'(zround);
  assign row_ext = {10'b0, e_row_r};
  assign col_ext = {10'b0, e_col_r};

  // datapath
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      pix_r <= in_tdata;
    end
    if (state_r == sgmd_pkg::S_DRA) begin
      dup_r[0]  <= up_rd;
      dmid_r[0] <= mid_rd;
    end
    if (state_r == sgmd_pkg::S_DRB) begin
      dup_r[1]  <= up_rd;
      dmid_r[1] <= mid_rd;
    end
    if (emit_go) begin
      ewin_r   <= ewin_nxt;
      e_row_r  <= out_row_r;
      e_col_r  <= out_col_r;
      e_last_r <= emit_last;
    end
    if (state_r == sgmd_pkg::S_GRAD) begin
      gx_r <= 11'(sum_r - sum_l);
      gy_r <= 11'(sum_b - sum_t);
    end
    if (state_r == sgmd_pkg::S_SQ) begin
      cx_r       <= 33'(den) << 20;
      cy_r       <= 33'(num) << 20;
      cz_r       <= '0;
      num_zero_r <= num == '0;
      swapped_r  <= ay > ax;
      gx_neg_r   <= gx_r[10];
      gy_neg_r   <= gy_r[10];
      sq_op_r    <= 22'(sqx) + 22'(sqy);
      sq_res_r   <= '0;
      sq_one_r   <= 22'd1 << 20;
    end
    if (state_r == sgmd_pkg::S_CALC) begin
      if (cy_r > 33'sd0) begin
        cx_r <= cx_r + ys;
        cy_r <= cy_r - xs;
        cz_r <= cz_r + 23'(sgmd_pkg::ATAN_TAB[step_r]);
      end else begin
        cx_r <= cx_r - ys;
        cy_r <= cy_r + xs;
        cz_r <= cz_r - 23'(sgmd_pkg::ATAN_TAB[step_r]);
      end
      if (sq_one_r != '0) begin
        if (sq_op_r >= sq_t) begin
          sq_op_r  <= sq_op_r - sq_t;
          sq_res_r <= (sq_res_r >> 1) + sq_one_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_one_r <= sq_one_r >> 2;
      end
    end
    if (state_r == sgmd_pkg::S_FIN && out_free) begin
      out_data_r <= {3'b0, col_ext[9:0], row_ext[9:0], dir, sq_res_r[10:0],
                     gy_r, gx_r};
      out_last_r <= e_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/sgmd_checker.sv
module sgmd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic        out_tlast
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // zero magnitude only with both gradients zero
  a_mag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[32:22] == 11'd0 |->
      out_tdata[10:0] == 11'd0 && out_tdata[21:11] == 11'd0)
    else $error("zero magnitude with nonzero gradient");

  // positive x axis gives angle zero
  a_dir_axis: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[21:11] == 11'd0 && !out_tdata[10] |->
      out_tdata[48:33] == 16'd0)
    else $error("nonzero direction on positive x axis");

endmodule

bind sobel_gradient_mag_dir sgmd_checker u_sgmd_checker (.*);
